### design/bottom_up_merge_sorter_defines.svh
// Assertion macros used by the sorter's top-level RTL file.
`ifndef BOTTOM_UP_MERGE_SORTER_DEFINES_SVH
`define BOTTOM_UP_MERGE_SORTER_DEFINES_SVH

`ifndef SYNTH
`define BUMS_ASSERT_IMPLIES(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed: same-cycle implication");
`define BUMS_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed: next-cycle implication");
`else
`define BUMS_ASSERT_IMPLIES(label, clk, rst_n, cond, expr)
`define BUMS_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif

`endif

### design/bums_pkg.sv
// Types and constants shared by the merge sorter modules.
package bums_pkg;

    localparam int SIZE_LOG2_W = 3;
    localparam logic [SIZE_LOG2_W-1:0] SIZE_LOG2_RESET = 3'd6;

    // Per-cycle command broadcast from the controller to every cell.
    typedef struct packed {
        logic clear;
        logic drain;
        logic load;
    } cell_ctrl_t;

endpackage

### design/bums_cell.sv
// One cell of the sorting row: holds one element and trades it with its neighbors.
module bums_cell #(
    parameter int VALUE_BITS = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  bums_pkg::cell_ctrl_t     ctrl,
    input  logic [VALUE_BITS-1:0]    new_value,
    input  logic [VALUE_BITS-1:0]    left_value,
    input  logic                     left_valid,
    input  logic                     left_ins,
    input  logic [VALUE_BITS-1:0]    right_value,
    input  logic                     right_valid,
    output logic [VALUE_BITS-1:0]    value,
    output logic                     valid,
    output logic                     ins
);

    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] value_next;
    logic                  valid_reg;
    logic                  valid_next;

    // The new element belongs at or before this cell when this cell is empty
    // or holds a strictly larger value; equal values keep arrival order.
    assign ins = !valid_reg || (new_value < value_reg);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        priority if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.drain)
        begin
            value_next = right_value;
            valid_next = right_valid;
        end
        else if (ctrl.load && ins)
        begin
            if (left_ins)
            begin
                value_next = left_value;
                valid_next = left_valid;
            end
            else
            begin
                value_next = new_value;
                valid_next = 1'b1;
            end
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

### design/bottom_up_merge_sorter.sv
// Block sorter: a row of compare cells sorts each loaded block ascending.
//
// Usage: set the block length with a beat on the cfg channel (size_log2,
// length 2**size_log2, 0 counts as 1, clipped to fit ELEMENTS). A write
// drops any partly loaded block. Then send the block's elements on the
// input channel (value, in_valid/in_ready), one beat per cycle. Each beat
// is inserted into its sorted place by the cell row as it arrives, so the
// block is already in order when its last element is taken.
// The cycle after the last input beat, out_valid rises and the block
// leaves from the head cell in ascending order, one beat per cycle, with
// last set on the final element. in_ready stays low while a block drains.
// Loading and draining do not overlap: the single shared row of cells is
// used first for insertion and then for draining, so the next block is
// not taken until the last one has left.
// When out_ready is low the head cell holds its element and the row waits.
// Reset empties the row, sets the length to 64 and waits for input.
`include "bottom_up_merge_sorter_defines.svh"

module bottom_up_merge_sorter #(
    parameter int ELEMENTS   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bums_pkg::SIZE_LOG2_W-1:0]  size_log2,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [VALUE_BITS-1:0]             value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [VALUE_BITS-1:0]             sorted_value,
    output logic                              last
);

    localparam int CNT_W  = $clog2(ELEMENTS + 1);
    localparam int MAX_LG = $clog2(ELEMENTS + 1) - 1;
    localparam int SW     = bums_pkg::SIZE_LOG2_W;

    typedef enum logic [0:0] {
        ST_LOAD,
        ST_EMIT
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [SW-1:0]     size_reg;
    logic [SW-1:0]     size_next;
    logic [CNT_W-1:0]  load_cnt_reg;
    logic [CNT_W-1:0]  load_cnt_next;
    logic [CNT_W-1:0]  emit_cnt_reg;
    logic [CNT_W-1:0]  emit_cnt_next;

    logic [SW-1:0]     size_eff;
    logic [CNT_W-1:0]  block_last;

    bums_pkg::cell_ctrl_t  ctrl;

    logic [VALUE_BITS-1:0] cell_value [ELEMENTS];
    logic                  cell_valid [ELEMENTS];
    logic                  cell_ins   [ELEMENTS];

    always_comb
    begin
        size_eff = (size_reg == '0) ? SW'(1) : size_reg;
        if (int'(size_eff) > MAX_LG)
        begin
            size_eff = SW'(MAX_LG);
        end
    end

    assign block_last = (CNT_W'(1) << size_eff) - CNT_W'(1);

    assign cfg_ready    = 1'b1;
    assign in_ready     = (state_reg == ST_LOAD);
    assign out_valid    = (state_reg == ST_EMIT);
    assign sorted_value = cell_value[0];
    assign last         = out_valid && (emit_cnt_reg == block_last);

    assign ctrl.clear = cfg_valid && cfg_ready;
    assign ctrl.load  = in_valid && in_ready;
    assign ctrl.drain = out_valid && out_ready;

    always_comb
    begin
        state_next    = state_reg;
        size_next     = size_reg;
        load_cnt_next = load_cnt_reg;
        emit_cnt_next = emit_cnt_reg;
        priority if (ctrl.clear)
        begin
            size_next     = size_log2;
            state_next    = ST_LOAD;
            load_cnt_next = '0;
            emit_cnt_next = '0;
        end
        else if (ctrl.load)
        begin
            if (load_cnt_reg == block_last)
            begin
                state_next    = ST_EMIT;
                load_cnt_next = '0;
                emit_cnt_next = '0;
            end
            else
            begin
                load_cnt_next = load_cnt_reg + CNT_W'(1);
            end
        end
        else if (ctrl.drain)
        begin
            if (last)
            begin
                state_next    = ST_LOAD;
                emit_cnt_next = '0;
            end
            else
            begin
                emit_cnt_next = emit_cnt_reg + CNT_W'(1);
            end
        end
        else
        begin
            state_next = state_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            size_reg     <= bums_pkg::SIZE_LOG2_RESET;
            load_cnt_reg <= '0;
            emit_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            size_reg     <= size_next;
            load_cnt_reg <= load_cnt_next;
            emit_cnt_reg <= emit_cnt_next;
        end
    end

    // Cell 0 holds the smallest element; loads shift larger ones rightward,
    // drains shift everything leftward toward the head.
    for (genvar i = 0; i < ELEMENTS; i++)
    begin : g_cell
        logic [VALUE_BITS-1:0] left_value;
        logic                  left_valid;
        logic                  left_ins;
        logic [VALUE_BITS-1:0] right_value;
        logic                  right_valid;

        if (i == 0)
        begin : g_head
            assign left_value = value;
            assign left_valid = 1'b0;
            assign left_ins   = 1'b0;
        end
        else
        begin : g_body
            assign left_value = cell_value[i-1];
            assign left_valid = cell_valid[i-1];
            assign left_ins   = cell_ins[i-1];
        end

        if (i == ELEMENTS - 1)
        begin : g_tail
            assign right_value = '0;
            assign right_valid = 1'b0;
        end
        else
        begin : g_inner
            assign right_value = cell_value[i+1];
            assign right_valid = cell_valid[i+1];
        end

        bums_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .new_value   (value),
            .left_value  (left_value),
            .left_valid  (left_valid),
            .left_ins    (left_ins),
            .right_value (right_value),
            .right_valid (right_valid),
            .value       (cell_value[i]),
            .valid       (cell_valid[i]),
            .ins         (cell_ins[i])
        );
    end

    `BUMS_ASSERT_IMPLIES(a_load_emit_excl, clk, rst_n, in_ready, !out_valid)
    `BUMS_ASSERT_IMPLIES(a_head_valid, clk, rst_n, out_valid, cell_valid[0])
    `BUMS_ASSERT_IMPLIES(a_load_in_range, clk, rst_n, in_ready, load_cnt_reg <= block_last)
    `BUMS_ASSERT_NEXT(a_last_reopens, clk, rst_n, out_valid && out_ready && last, in_ready && !cell_valid[0])

endmodule

### bench/bottom_up_merge_sorter_test.sv
// Self-checking testbench for the bottom-up merge sorter: random blocks, size changes, stalls.
`timescale 1ns / 100ps

module bottom_up_merge_sorter_test;

    localparam int ELEMENTS     = 64;
    localparam int VALUE_BITS   = 32;
    localparam int HALF_PERIOD  = 4;
    localparam int SETTLE_GAP   = 16;
    localparam int DRAIN_GAP    = 80;
    localparam int HOLD_CYCLES  = 240;
    localparam int TIMEOUT_NS   = 400000;

    typedef logic [VALUE_BITS-1:0] element_t;
    typedef logic [bums_pkg::SIZE_LOG2_W-1:0] size_code_t;

    // Predicts the sorted output of every complete block and checks the output beats.
    class sort_scoreboard;
        int unsigned capacity;
        int unsigned length;
        element_t    loading[$];
        element_t    sorted_queue[$];
        logic        last_queue[$];
        int unsigned mismatches;
        int unsigned results_seen;
        int unsigned blocks_sorted;
        int unsigned blocks_dropped;

        function new(int unsigned max_elements);
            capacity = max_elements;
            mismatches = 0;
            results_seen = 0;
            blocks_sorted = 0;
            blocks_dropped = 0;
            note_size(bums_pkg::SIZE_LOG2_RESET);
            blocks_dropped = 0;
        endfunction

        // A size write restarts loading, so a partly loaded block is lost.
        function void note_size(size_code_t code);
            int unsigned lg;
            lg = (code == 0) ? 1 : code;
            length = 1 << lg;
            while (length > capacity && length > 2)
                length = length >> 1;
            if (loading.size() != 0)
                blocks_dropped++;
            loading.delete();
        endfunction

        function void sort_into_expectations();
            element_t keys[$];
            element_t key;
            int       j;
            keys = loading;
            for (int i = 1; i < keys.size(); i++)
            begin
                key = keys[i];
                j = i;
                while (j > 0 && keys[j-1] > key)
                begin
                    keys[j] = keys[j-1];
                    j--;
                end
                keys[j] = key;
            end
            foreach (keys[i])
            begin
                sorted_queue.push_back(keys[i]);
                last_queue.push_back(i == keys.size() - 1);
            end
            blocks_sorted++;
            loading.delete();
        endfunction

        function void note_value(element_t v);
            loading.push_back(v);
            if (loading.size() == length)
                sort_into_expectations();
        endfunction

        function void flag(string what, element_t exp_v, logic exp_l, element_t got_v,
                           logic got_l);
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH (%s): expected value %h last %b, got value %h last %b",
                         what, exp_v, exp_l, got_v, got_l);
        endfunction

        function void check_output(element_t got_v, logic got_l);
            element_t exp_v;
            logic     exp_l;
            results_seen++;
            if (sorted_queue.size() == 0)
            begin
                flag("nothing expected", 'x, 1'bx, got_v, got_l);
            end
            else
            begin
                exp_v = sorted_queue.pop_front();
                exp_l = last_queue.pop_front();
                if (got_v !== exp_v)
                    flag("sorted_value", exp_v, exp_l, got_v, got_l);
                else if (got_l !== exp_l)
                    flag("last", exp_v, exp_l, got_v, got_l);
            end
        endfunction

        function int unsigned pending();
            return sorted_queue.size();
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    size_code_t size_log2 = '0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    element_t   value = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    element_t   sorted_value;
    logic       last;

    bit no_idle = 1'b0;
    bit hold_request = 1'b0;

    sort_scoreboard sorter_board = new(ELEMENTS);

    bottom_up_merge_sorter #(
        .ELEMENTS   (ELEMENTS),
        .VALUE_BITS (VALUE_BITS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .size_log2    (size_log2),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sorted_value (sorted_value),
        .last         (last)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Mix of wide random values, small values that tie often, and the two extremes.
    function automatic element_t pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 7);
            1: return ($urandom_range(0, 1) != 0) ? '1 : '0;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_value(input element_t v);
        while (!no_idle && $urandom_range(0, 99) < 15)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sorter_board.note_value(v);
    endtask

    // Waits until every sorted beat has come back, plus a margin for work still in flight.
    task automatic settle();
        while (sorter_board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_GAP) @(posedge clk);
    endtask

    task automatic start_phase(input size_code_t code);
        in_valid <= 1'b0;
        settle();
        cfg_valid <= 1'b1;
        size_log2 <= code;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sorter_board.note_size(code);
    endtask

    // Sends whole blocks and, if asked, a few values of a block that is never finished.
    task automatic run_phase(input size_code_t code, input int unsigned blocks,
                             input bit with_tail);
        int unsigned tail;
        start_phase(code);
        tail = 0;
        if (with_tail)
            tail = $urandom_range(1, (sorter_board.length > 6) ? 5 : sorter_board.length - 1);
        repeat (blocks * sorter_board.length + tail) send_value(pick_value());
    endtask

    // Output side: random back-pressure, plus one long hold-off on request.
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sorter_board.check_output(sorted_value, last);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= no_idle || ($urandom_range(0, 99) >= 15);
            end
        end
    end

    initial
    begin
        size_code_t code;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Two-element blocks: already ordered, reversed, and a tie.
        start_phase(3'd1);
        send_value('0);
        send_value('1);
        send_value('1);
        send_value('0);
        send_value(32'd5);
        send_value(32'd5);

        // A size code of zero still means two elements; the odd value is dropped later.
        start_phase(3'd0);
        send_value(32'hFFFF_0000);
        send_value(32'h0000_FFFF);
        send_value(32'h1234_5678);

        start_phase(3'd2);
        send_value(32'hAAAA_AAAA);
        send_value(32'd3);
        send_value(32'd3);
        send_value(32'd0);
        send_value(32'h5555_5555);
        send_value('1);
        send_value(32'd1);
        send_value(32'h8000_0000);
        send_value(32'd7);
        send_value(32'd9);

        // Outputs held off long enough that the input side has to stall.
        start_phase(3'd2);
        hold_request = 1'b1;
        repeat (2 * sorter_board.length) send_value(pick_value());

        for (int p = 0; p < 2; p++)
        begin
            code = $urandom_range(0, 3);
            run_phase(code, 1, $urandom_range(0, 1));
        end

        run_phase(3'd6, 0, 1'b1);

        // Code 7 asks for more than the store holds and is clipped to its full size.
        no_idle = 1'b1;
        run_phase(3'd7, 1, 1'b0);
        no_idle = 1'b0;

        run_phase($urandom_range(1, 3), 1, 1'b0);

        in_valid <= 1'b0;
        while (sorter_board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_GAP) @(posedge clk);

        $display("Sorted %0d blocks of 2 to %0d values and checked %0d output beats;",
                 sorter_board.blocks_sorted, ELEMENTS, sorter_board.results_seen);
        $display("%0d partly loaded blocks were dropped by a size change, %0d mismatches.",
                 sorter_board.blocks_dropped, sorter_board.mismatches);
        if (sorter_board.mismatches == 0 && sorter_board.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Timed out with %0d sorted values still expected.", sorter_board.pending());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### bottom_up_merge_sorter.f
+incdir+design
design/bums_pkg.sv
design/bums_cell.sv
design/bottom_up_merge_sorter.sv
bench/bottom_up_merge_sorter_test.sv
